/* sv/sctm_pkg.sv */
// shared constants, codes and control structs for the sigma-clip threshold unit
// no dependencies; every other file refers to it by scoped names
package sctm_pkg;

    // sizing of the accumulators and arithmetic
    localparam int COUNT_BITS  = 20;
    localparam int PIXEL_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int TOTAL_W     = COUNT_BITS + 1;
    localparam int SUM_W       = PIXEL_BITS + COUNT_BITS;
    localparam int SQ_W        = 2 * PIXEL_BITS + COUNT_BITS;
    localparam int DIVD_W      = SQ_W + 2 * FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);
    localparam int MEAN_W      = 24;
    localparam int M2_W        = 48;
    localparam int SIGMA_W     = 24;
    localparam int K_W         = 16;
    localparam int DROP_W      = 32;
    localparam int THR_W       = 32;
    localparam int ROOT_STEPS  = M2_W / 2;
    localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS + 1);
    localparam int ACTION_W    = 2;
    localparam int OUT_DATA_W  = 104;

    localparam logic [DIV_CNT_W-1:0]  DIV_STEPS  = DIV_CNT_W'(DIVD_W);
    localparam logic [ROOT_CNT_W-1:0] ROOT_LOOPS = ROOT_CNT_W'(ROOT_STEPS);

    // item kinds
    localparam logic [ACTION_W-1:0] ACT_ACCUM    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FINISH   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLASSIFY = 2'd2;

    // clip factor after reset, 2.5 in Q8.8
    localparam logic [K_W-1:0] CLIP_RESET = 16'd640;

    // lowest threshold
    localparam logic [THR_W-1:0] THR_MIN = 32'h8000_0000;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic div_start;
        logic div_sel;      // 0 mean, 1 second moment
        logic mean_ld;
        logic m2_ld;
        logic msq_ld;
        logic var_ld;
        logic sqrt_start;
        logic sigma_ld;
        logic drop_ld;
        logic fin_emit;
        logic fin_empty;
    } sctm_cmd_t;

    // status back to the sequencer
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic total_zero;
    } sctm_stat_t;

endpackage

/* sv/sctm_div.sv */
// iterative restoring divider, one quotient bit a cycle
// depends on sctm_pkg for widths
module sctm_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sctm_pkg::DIVD_W-1:0]         dividend,
    input  logic [sctm_pkg::TOTAL_W-1:0]        divisor,
    output logic                                done,
    output logic [sctm_pkg::DIVD_W-1:0]         quotient
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [sctm_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [sctm_pkg::DIVD_W-1:0]        quo_reg, quo_next;
    logic [sctm_pkg::TOTAL_W-1:0]       rem_reg, rem_next;
    logic [sctm_pkg::TOTAL_W-1:0]       dsr_reg, dsr_next;
    logic [sctm_pkg::TOTAL_W:0]         trial;
    logic [sctm_pkg::TOTAL_W:0]         diff;
    logic                               ge;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[sctm_pkg::DIVD_W-1]};
        ge    = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = sctm_pkg::DIV_STEPS;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[sctm_pkg::DIVD_W-2:0], ge};
            rem_next = ge ? diff[sctm_pkg::TOTAL_W-1:0] : trial[sctm_pkg::TOTAL_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/sctm_sqrt.sv */
// digit-by-digit integer square root, one result bit a cycle
// depends on sctm_pkg for widths
module sctm_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sctm_pkg::M2_W-1:0]       radicand,
    output logic                            done,
    output logic [sctm_pkg::SIGMA_W-1:0]    root
);

    localparam logic [sctm_pkg::M2_W-1:0] TOP_BIT = {2'b01, {(sctm_pkg::M2_W-2){1'b0}}};

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [sctm_pkg::ROOT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sctm_pkg::M2_W-1:0]          v_reg, v_next;
    logic [sctm_pkg::M2_W-1:0]          res_reg, res_next;
    logic [sctm_pkg::M2_W-1:0]          bit_reg, bit_next;
    logic [sctm_pkg::M2_W:0]            trial;
    logic                               take;

    // trial subtraction
    always_comb
    begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        take  = ({1'b0, v_reg} >= trial);
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = sctm_pkg::ROOT_LOOPS;
            v_next    = radicand;
            res_next  = '0;
            bit_next  = TOP_BIT;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                v_next   = v_reg - trial[sctm_pkg::M2_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[sctm_pkg::SIGMA_W-1:0];

endmodule

/* sv/sctm_datapath.sv */
// accumulators, classifier, finish arithmetic and the result register
// depends on sctm_pkg, sctm_div and sctm_sqrt
module sctm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_accept,
    input  logic [sctm_pkg::ACTION_W-1:0]       action,
    input  logic [sctm_pkg::PIXEL_BITS-1:0]     pixel,
    input  logic                                cfg_wr_en,
    input  logic [sctm_pkg::K_W-1:0]            cfg_wr_data,
    input  sctm_pkg::sctm_cmd_t                 cmd,
    output sctm_pkg::sctm_stat_t                stat,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [sctm_pkg::OUT_DATA_W-1:0]     out_data
);

    logic [sctm_pkg::K_W-1:0]       k_reg;
    logic [sctm_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [sctm_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [sctm_pkg::SQ_W-1:0]      sq_reg, sq_next;
    logic signed [sctm_pkg::THR_W-1:0] clip_reg, clip_next;
    logic [sctm_pkg::TOTAL_W-1:0]   flag_reg, flag_next;

    logic [sctm_pkg::MEAN_W-1:0]    mean_reg;
    logic [sctm_pkg::M2_W-1:0]      m2_reg;
    logic [sctm_pkg::M2_W-1:0]      msq_reg;
    logic [sctm_pkg::M2_W-1:0]      var_reg;
    logic [sctm_pkg::SIGMA_W-1:0]   sigma_reg;
    logic [sctm_pkg::DROP_W-1:0]    drop_reg;

    logic                           out_valid_reg, out_valid_next;
    logic                           o_sig_reg;
    logic [sctm_pkg::TOTAL_W-1:0]   o_cnt_reg;
    logic [sctm_pkg::MEAN_W-1:0]    o_mean_reg;
    logic [sctm_pkg::SIGMA_W-1:0]   o_sigma_reg;
    logic [sctm_pkg::THR_W-1:0]     o_thr_reg;

    logic                           acc_go;
    logic                           cls_go;
    logic                           fin_go;
    logic                           hit;
    logic [2*sctm_pkg::PIXEL_BITS-1:0] pix_sq;
    logic signed [sctm_pkg::THR_W-1:0] pix_q8;
    logic [sctm_pkg::DIVD_W-1:0]    div_dividend;
    logic                           div_done;
    logic [sctm_pkg::DIVD_W-1:0]    div_quo;
    logic                           sqrt_done;
    logic [sctm_pkg::SIGMA_W-1:0]   sqrt_root;
    logic [2*sctm_pkg::MEAN_W-1:0]  mean_sq;
    logic [sctm_pkg::K_W+sctm_pkg::SIGMA_W-1:0] k_sigma;
    logic signed [sctm_pkg::THR_W+1:0] thr_wide;
    logic [sctm_pkg::THR_W-1:0]     thr_sat;

    // item decode
    always_comb
    begin
        acc_go = in_accept && (action == sctm_pkg::ACT_ACCUM) && !total_reg[sctm_pkg::COUNT_BITS];
        cls_go = in_accept && (action == sctm_pkg::ACT_CLASSIFY);
        fin_go = cmd.fin_emit || cmd.fin_empty;
        pix_sq = pixel * pixel;
        pix_q8 = $signed({{(sctm_pkg::THR_W-sctm_pkg::PIXEL_BITS-sctm_pkg::FRAC_BITS){1'b0}},
                          pixel, {sctm_pkg::FRAC_BITS{1'b0}}});
        hit    = (pix_q8 <= clip_reg);
    end

    // shared divider: mean first, then second moment
    always_comb
    begin
        if (cmd.div_sel)
        begin
            div_dividend = {sq_reg, {(2*sctm_pkg::FRAC_BITS){1'b0}}};
        end
        else
        begin
            div_dividend = {{(sctm_pkg::DIVD_W-sctm_pkg::SUM_W-sctm_pkg::FRAC_BITS){1'b0}},
                            sum_reg, {sctm_pkg::FRAC_BITS{1'b0}}};
        end
    end

    sctm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    sctm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (var_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // threshold from mean and scaled sigma, floored at the lowest value
    always_comb
    begin
        mean_sq  = mean_reg * mean_reg;
        k_sigma  = k_reg * sigma_reg;
        thr_wide = $signed({{(sctm_pkg::THR_W+2-sctm_pkg::MEAN_W){1'b0}}, mean_reg})
                 - $signed({2'b00, drop_reg});
        if (thr_wide < $signed({{2{1'b1}}, sctm_pkg::THR_MIN}))
        begin
            thr_sat = sctm_pkg::THR_MIN;
        end
        else
        begin
            thr_sat = thr_wide[sctm_pkg::THR_W-1:0];
        end
    end

    // accumulator and counter updates
    always_comb
    begin
        total_next = total_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        clip_next  = clip_reg;
        flag_next  = flag_reg;
        if (acc_go)
        begin
            total_next = total_reg + 1'b1;
            sum_next   = sum_reg + {{(sctm_pkg::SUM_W-sctm_pkg::PIXEL_BITS){1'b0}}, pixel};
            sq_next    = sq_reg + {{(sctm_pkg::SQ_W-2*sctm_pkg::PIXEL_BITS){1'b0}}, pix_sq};
        end
        if (cls_go && hit && !flag_reg[sctm_pkg::COUNT_BITS])
        begin
            flag_next = flag_reg + 1'b1;
        end
        if (fin_go)
        begin
            total_next = '0;
            sum_next   = '0;
            sq_next    = '0;
            flag_next  = '0;
            clip_next  = cmd.fin_empty ? $signed(sctm_pkg::THR_MIN) : $signed(thr_sat);
        end
    end

    // result register hand-off
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cls_go || fin_go)
        begin
            out_valid_next = 1'b1;
        end
    end

    // state with a defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= sctm_pkg::CLIP_RESET;
            total_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            clip_reg      <= '0;
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                k_reg <= cfg_wr_data;
            end
            total_reg     <= total_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            clip_reg      <= clip_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // finish arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.mean_ld)
        begin
            mean_reg <= div_quo[sctm_pkg::MEAN_W-1:0];
        end
        if (cmd.m2_ld)
        begin
            m2_reg <= div_quo[sctm_pkg::M2_W-1:0];
        end
        if (cmd.msq_ld)
        begin
            msq_reg <= mean_sq;
        end
        if (cmd.var_ld)
        begin
            var_reg <= (m2_reg > msq_reg) ? (m2_reg - msq_reg) : '0;
        end
        if (cmd.sigma_ld)
        begin
            sigma_reg <= sqrt_root;
        end
        if (cmd.drop_ld)
        begin
            drop_reg <= k_sigma[sctm_pkg::K_W+sctm_pkg::SIGMA_W-1:sctm_pkg::FRAC_BITS];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cls_go)
        begin
            o_sig_reg   <= hit;
            o_cnt_reg   <= flag_next;
            o_mean_reg  <= '0;
            o_sigma_reg <= '0;
            o_thr_reg   <= '0;
        end
        else if (fin_go)
        begin
            o_sig_reg   <= 1'b0;
            o_cnt_reg   <= '0;
            o_mean_reg  <= cmd.fin_empty ? '0 : mean_reg;
            o_sigma_reg <= cmd.fin_empty ? '0 : sigma_reg;
            o_thr_reg   <= cmd.fin_empty ? sctm_pkg::THR_MIN : thr_sat;
        end
    end

    assign stat.div_done   = div_done;
    assign stat.sqrt_done  = sqrt_done;
    assign stat.total_zero = (total_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_data  = {2'b00, o_thr_reg, o_sigma_reg, o_mean_reg, o_cnt_reg, o_sig_reg};

    // a new result never lands on one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cls_go || fin_go) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // pixel count never passes its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= {1'b1, {sctm_pkg::COUNT_BITS{1'b0}}})
        else $error("pixel count beyond limit");

    // finish leaves the accumulators empty
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (total_reg == '0) && (sum_reg == '0) && (sq_reg == '0) && (flag_reg == '0))
        else $error("accumulators not cleared by finish");

    // each unsaturated hit adds exactly one to the flagged count
    assert property (@(posedge clk) disable iff (!rst_n)
        (cls_go && hit && !flag_reg[sctm_pkg::COUNT_BITS]) |=>
            (flag_reg == $past(flag_reg) + 1'b1))
        else $error("flagged count step wrong");

endmodule

/* sv/sctm_ctrl.sv */
// finish sequencer: steps the datapath through divide, square root and threshold
// depends on sctm_pkg for the command and status structs
module sctm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fin_accept,
    input  sctm_pkg::sctm_stat_t    stat,
    output sctm_pkg::sctm_cmd_t     cmd,
    output logic                    busy
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIVM   = 3'd1;
    localparam logic [2:0] ST_DIVQ   = 3'd2;
    localparam logic [2:0] ST_VAR    = 3'd3;
    localparam logic [2:0] ST_SQRTGO = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_DROP   = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (fin_accept)
                begin
                    if (stat.total_zero)
                    begin
                        cmd.fin_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVM;
                    end
                end
            end
            ST_DIVM:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_ld   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b1;
                    state_next    = ST_DIVQ;
                end
            end
            ST_DIVQ:
            begin
                cmd.div_sel = 1'b1;
                cmd.msq_ld  = 1'b1;
                if (stat.div_done)
                begin
                    cmd.m2_ld  = 1'b1;
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                cmd.var_ld = 1'b1;
                state_next = ST_SQRTGO;
            end
            ST_SQRTGO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.sigma_ld = 1'b1;
                    state_next   = ST_DROP;
                end
            end
            ST_DROP:
            begin
                cmd.drop_ld = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.fin_emit = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* sv/sigma_clip_threshold_mask_unit.sv */
// top level of the sigma-clip threshold unit: stream ports, config port, glue
// depends on sctm_pkg, sctm_datapath and sctm_ctrl
//
// Usage:
//   Input beats (s_axis) carry a pixel in tdata and the item kind in tuser:
//   accumulate, finish or classify. Accumulate beats add the pixel to the
//   count, sum and sum of squares and give no output. A finish beat produces
//   one output beat with mean, sigma and threshold (Q8) and clears the
//   accumulators and the flagged counter. A classify beat produces one output
//   beat flagging a pixel at or below the current threshold, with the running
//   flagged count. Unused kinds are dropped.
//   Throughput: accumulate and classify beats go at one per cycle while the
//   result register drains; a classify result is registered and appears in
//   the cycle after its beat. A finish result follows its beat after two
//   passes of the 68-step shared divider, the 24-step square root and the
//   sequencing states; s_axis_tready is low in between. With nothing
//   accumulated a finish result appears in the cycle after its beat.
//   The result sits in a single output register; while it waits for
//   m_axis_tready, beats that need no result slot are still taken only if
//   the register is free or drains that cycle.
//   Reset clears the accumulators, the threshold (to zero) and the counters
//   and sets the clip factor to 2.5. cfg_wr_data is written when cfg_wr_en
//   is high and should only change while the unit is idle.
module sigma_clip_threshold_mask_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,   // pixel[15:0]
    input  logic [sctm_pkg::ACTION_W-1:0]       s_axis_tuser,   // action[1:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // is_signal[0], signal_count[21:1], mean_q8[45:22], sigma_q8[69:46],
    // threshold_q8[101:70], zero fill[103:102]
    output logic [sctm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [sctm_pkg::K_W-1:0]            cfg_wr_data
);

    logic                   in_accept;
    logic                   fin_accept;
    logic                   busy;
    sctm_pkg::sctm_cmd_t    cmd;
    sctm_pkg::sctm_stat_t   stat;

    // take a beat when no finish runs and the result slot is free or draining
    assign s_axis_tready = !busy && (!m_axis_tvalid || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign fin_accept    = in_accept && (s_axis_tuser == sctm_pkg::ACT_FINISH);

    sctm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_accept (fin_accept),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    sctm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .action      (s_axis_tuser),
        .pixel       (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata)
    );

endmodule
